// ----- rtl/core/espd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// espd_pkg
// Shared widths, register codes, reset values and stage word types for the
// encoder speed PID drive.
// ----------------------------------------------------------------------------
package espd_pkg;

  // Field widths
  localparam int CNT_W   = 16;
  localparam int TGT_W   = 24;
  localparam int ERR_W   = TGT_W + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int SUM_W   = 32;
  localparam int LIM_W   = 31;
  localparam int GAIN_W  = 16;
  localparam int DRV_W   = 32;
  localparam int DUTY_W  = 31;

  // Product and accumulator widths (exact, Q16.16)
  localparam int PP_W    = GAIN_W + ERR_W;
  localparam int PI_W    = GAIN_W + SUM_W;
  localparam int PD_W    = GAIN_W + DIFF_W;
  localparam int ACC_W   = PI_W + 2;

  // Bus widths
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 88;
  localparam int OUT_FIELDS_W = CNT_W + DRV_W + DUTY_W + 2;

  // Register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_ENABLE     = 3'd0,
    REG_TARGET     = 3'd1,
    REG_GAIN_P     = 3'd2,
    REG_GAIN_I     = 3'd3,
    REG_GAIN_D     = 3'd4,
    REG_SUM_LIMIT  = 3'd5,
    REG_DRIVE_MIN  = 3'd6,
    REG_DRIVE_MAX  = 3'd7
  } reg_idx_t;

  // Reset values
  localparam logic signed [GAIN_W-1:0] GAIN_P_RST    = 16'sd256;
  localparam logic        [LIM_W-1:0]  SUM_LIMIT_RST = 31'd327680;
  localparam logic signed [DRV_W-1:0]  DRIVE_MIN_RST = -32'sd65536;
  localparam logic signed [DRV_W-1:0]  DRIVE_MAX_RST = 32'sd65536;

  // Most negative drive; its magnitude does not fit the duty field
  localparam logic signed [DRV_W-1:0]  DRIVE_NEG_FULL = {1'b1, {(DRV_W-1){1'b0}}};

  typedef struct packed {
    logic                      enable;
    logic signed [TGT_W-1:0]   speed_target;
    logic signed [GAIN_W-1:0]  gain_p;
    logic signed [GAIN_W-1:0]  gain_i;
    logic signed [GAIN_W-1:0]  gain_d;
    logic        [LIM_W-1:0]   sum_limit;
    logic signed [DRV_W-1:0]   drive_min;
    logic signed [DRV_W-1:0]   drive_max;
  } cfg_t;

  // Error stage -> multiply stage
  typedef struct packed {
    logic                      en;
    logic signed [CNT_W-1:0]   delta;
    logic signed [ERR_W-1:0]   err;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [SUM_W-1:0]   error_sum;
  } err_word_t;

  // Accumulate stage -> output stage
  typedef struct packed {
    logic                      en;
    logic signed [CNT_W-1:0]   delta;
    logic signed [ACC_W-1:0]   acc;
  } acc_word_t;

endpackage

// ----- rtl/core/encoder_speed_pid_drive.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_speed_pid_drive
// PID speed loop on encoder count deltas with a clamped error sum and a
// clamped Q16.16 drive, decoded into duty, direction and brake.
// ----------------------------------------------------------------------------
// Pipeline: input, error, product, sum and result registers.
// Throughput: one word per cycle while m_tready keeps the output moving;
// last count, error sum and last error update at the same edge as the
// error stage register. A waiting result stalls a stage only when the
// stage ahead of it is full.
// Reset (rst, synchronous): pipeline empty, loop state zero, defaults loaded.
// ----------------------------------------------------------------------------
module encoder_speed_pid_drive (
  input  logic                               clk,
  input  logic                               rst,
  // s_tdata: [15:0] encoder_count
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [espd_pkg::IN_TDATA_W-1:0]    s_tdata,
  // m_tdata: [15:0] measured_delta, [47:16] drive_value,
  //          [78:48] duty_magnitude, [79] dir_level, [80] braking, rest zero
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [espd_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [espd_pkg::ADDR_W-1:0]        paddr,
  input  logic [espd_pkg::DATA_W-1:0]        pwdata,
  output logic [espd_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import espd_pkg::*;

  cfg_t       cfg;
  logic       e_valid;
  logic       e_ready;
  err_word_t  e_word;
  logic       a_valid;
  logic       a_ready;
  acc_word_t  a_word;

  espd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  espd_err u_err (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_count  (s_tdata[CNT_W-1:0]),
    .out_valid (e_valid),
    .out_ready (e_ready),
    .out_word  (e_word)
  );

  espd_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (e_valid),
    .in_ready  (e_ready),
    .in_word   (e_word),
    .out_valid (a_valid),
    .out_ready (a_ready),
    .out_word  (a_word)
  );

  espd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (a_valid),
    .in_ready  (a_ready),
    .in_word   (a_word),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

// ----- rtl/core/espd_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// espd_cfg
// APB register file holding the control law settings.
// ----------------------------------------------------------------------------
module espd_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [espd_pkg::ADDR_W-1:0]  paddr,
  input  logic [espd_pkg::DATA_W-1:0]  pwdata,
  output logic [espd_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output espd_pkg::cfg_t               cfg
);
  import espd_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable       <= 1'b0;
      cfg.speed_target <= '0;
      cfg.gain_p       <= GAIN_P_RST;
      cfg.gain_i       <= '0;
      cfg.gain_d       <= '0;
      cfg.sum_limit    <= SUM_LIMIT_RST;
      cfg.drive_min    <= DRIVE_MIN_RST;
      cfg.drive_max    <= DRIVE_MAX_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_ENABLE:    cfg.enable       <= pwdata[0];
        REG_TARGET:    cfg.speed_target <= pwdata[TGT_W-1:0];
        REG_GAIN_P:    cfg.gain_p       <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:    cfg.gain_i       <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:    cfg.gain_d       <= pwdata[GAIN_W-1:0];
        REG_SUM_LIMIT: cfg.sum_limit    <= pwdata[LIM_W-1:0];
        REG_DRIVE_MIN: cfg.drive_min    <= pwdata[DRV_W-1:0];
        REG_DRIVE_MAX: cfg.drive_max    <= pwdata[DRV_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux, signed fields sign-extended
  always_comb begin
    unique case (idx)
      REG_ENABLE:    prdata = {{(DATA_W-1){1'b0}}, cfg.enable};
      REG_TARGET:    prdata = DATA_W'(cfg.speed_target);
      REG_GAIN_P:    prdata = DATA_W'(cfg.gain_p);
      REG_GAIN_I:    prdata = DATA_W'(cfg.gain_i);
      REG_GAIN_D:    prdata = DATA_W'(cfg.gain_d);
      REG_SUM_LIMIT: prdata = {1'b0, cfg.sum_limit};
      REG_DRIVE_MIN: prdata = cfg.drive_min;
      REG_DRIVE_MAX: prdata = cfg.drive_max;
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/espd_err.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// espd_err
// Input register and error stage: count delta, speed error, clamped error
// sum and error difference. Holds the loop state.
// ----------------------------------------------------------------------------
module espd_err (
  input  logic                          clk,
  input  logic                          rst,
  input  espd_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [espd_pkg::CNT_W-1:0]    in_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output espd_pkg::err_word_t           out_word
);
  import espd_pkg::*;

  // Input register
  logic             iv;
  logic [CNT_W-1:0] count_q;

  // Loop state
  logic [CNT_W-1:0]         last_count;
  logic signed [SUM_W-1:0]  error_sum;
  logic signed [ERR_W-1:0]  last_error;

  logic                       e_adv;
  logic                       fire;
  logic signed [CNT_W-1:0]    delta_c;
  logic signed [TGT_W-1:0]    delta_sh;
  logic signed [ERR_W-1:0]    err_c;
  logic signed [DIFF_W-1:0]   diff_c;
  logic signed [SUM_W:0]      sum_raw;
  logic signed [SUM_W:0]      lim_pos;
  logic signed [SUM_W:0]      lim_neg;
  logic signed [SUM_W:0]      sum_clamped;
  logic signed [SUM_W-1:0]    sum_next;

  assign e_adv    = !out_valid || out_ready;
  assign in_ready = !iv || e_adv;
  assign fire     = iv && e_adv;

  // Delta, error and clamped sum
  assign delta_c  = CNT_W'(count_q - last_count);
  assign delta_sh = {delta_c, 8'h00};
  assign err_c    = ERR_W'(cfg.speed_target) - ERR_W'(delta_sh);
  assign diff_c   = DIFF_W'(err_c) - DIFF_W'(last_error);
  assign sum_raw  = (SUM_W+1)'(error_sum) + (SUM_W+1)'(err_c);
  assign lim_pos  = $signed({2'b00, cfg.sum_limit});
  assign lim_neg  = -lim_pos;

  always_comb begin
    priority if (sum_raw > lim_pos) begin
      sum_clamped = lim_pos;
    end else if (sum_raw < lim_neg) begin
      sum_clamped = lim_neg;
    end else begin
      sum_clamped = sum_raw;
    end
  end

  assign sum_next = cfg.enable ? sum_clamped[SUM_W-1:0] : error_sum;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      iv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) iv <= in_valid;
      if (e_adv)    out_valid <= iv;
    end
  end

  // Loop state, updated once per word leaving the input register (error sum and last error only while enabled)
  always_ff @(posedge clk) begin
    if (rst) begin
      last_count <= '0;
      error_sum  <= '0;
      last_error <= '0;
    end else if (fire) begin
      last_count <= count_q;
      if (cfg.enable) begin
        error_sum  <= sum_next;
        last_error <= err_c;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) count_q <= in_count;
    if (fire) begin
      out_word.en        <= cfg.enable;
      out_word.delta     <= delta_c;
      out_word.err       <= err_c;
      out_word.diff      <= diff_c;
      out_word.error_sum <= sum_next;
    end
  end

`ifndef SYNTH
  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    fire |=> last_count == $past(count_q))
    else $error("last_count did not take the sample");
  a_hold_disabled: assert property (@(posedge clk) disable iff (rst)
    (fire && !cfg.enable) |=> ($stable(error_sum) && $stable(last_error)))
    else $error("loop state changed while disabled");
  a_no_update_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |=> ($stable(last_count) && $stable(error_sum)))
    else $error("loop state changed without a word");
`endif

endmodule

// ----- rtl/core/espd_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// espd_mac
// Gain products in one stage, their exact sum in the next.
// ----------------------------------------------------------------------------
module espd_mac (
  input  logic                    clk,
  input  logic                    rst,
  input  espd_pkg::cfg_t          cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  espd_pkg::err_word_t     in_word,
  output logic                    out_valid,
  input  logic                    out_ready,
  output espd_pkg::acc_word_t     out_word
);
  import espd_pkg::*;

  logic                      mv;
  logic                      m_adv;
  logic                      m_en;
  logic signed [CNT_W-1:0]   m_delta;
  logic signed [PP_W-1:0]    prod_p;
  logic signed [PI_W-1:0]    prod_i;
  logic signed [PD_W-1:0]    prod_d;
  logic signed [ACC_W-1:0]   acc_c;

  assign m_adv    = !out_valid || out_ready;
  assign in_ready = !mv || m_adv;

  assign acc_c = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      mv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) mv <= in_valid;
      if (m_adv)    out_valid <= mv;
    end
  end

  // Products, then sum
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      m_en    <= in_word.en;
      m_delta <= in_word.delta;
      prod_p  <= PP_W'(cfg.gain_p) * PP_W'(in_word.err);
      prod_i  <= PI_W'(cfg.gain_i) * PI_W'(in_word.error_sum);
      prod_d  <= PD_W'(cfg.gain_d) * PD_W'(in_word.diff);
    end
    if (mv && m_adv) begin
      out_word.en    <= m_en;
      out_word.delta <= m_delta;
      out_word.acc   <= acc_c;
    end
  end

endmodule

// ----- rtl/core/espd_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// espd_out
// Drive clamp, duty and direction decode, result register.
// ----------------------------------------------------------------------------
module espd_out (
  input  logic                               clk,
  input  logic                               rst,
  input  espd_pkg::cfg_t                     cfg,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  espd_pkg::acc_word_t                in_word,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [espd_pkg::OUT_TDATA_W-1:0]   out_data
);
  import espd_pkg::*;

  logic signed [ACC_W-1:0]  hi_x;
  logic signed [ACC_W-1:0]  lo_x;
  logic signed [ACC_W-1:0]  hi_cl;
  logic signed [ACC_W-1:0]  both_cl;
  logic signed [DRV_W-1:0]  drive_c;
  logic signed [DRV_W-1:0]  neg_c;
  logic [DUTY_W-1:0]        duty_c;
  logic                     dir_c;
  logic                     brk_c;

  // Result register fields
  logic signed [CNT_W-1:0]  delta_q;
  logic signed [DRV_W-1:0]  drive_q;
  logic [DUTY_W-1:0]        duty_q;
  logic                     dir_q;
  logic                     brk_q;

  assign in_ready = !out_valid || out_ready;

  // Upper clamp first, lower second
  assign hi_x = ACC_W'(cfg.drive_max);
  assign lo_x = ACC_W'(cfg.drive_min);

  always_comb begin
    hi_cl   = (in_word.acc > hi_x) ? hi_x : in_word.acc;
    both_cl = (hi_cl < lo_x) ? lo_x : hi_cl;
  end

  assign drive_c = in_word.en ? both_cl[DRV_W-1:0] : '0;
  assign neg_c   = -drive_c;

  // Direction and duty
  always_comb begin
    priority if (drive_c > 0) begin
      duty_c = drive_c[DUTY_W-1:0];
      dir_c  = 1'b0;
      brk_c  = 1'b0;
    end else if (drive_c < 0) begin
      duty_c = (drive_c == DRIVE_NEG_FULL) ? '1 : neg_c[DUTY_W-1:0];
      dir_c  = 1'b1;
      brk_c  = 1'b0;
    end else begin
      duty_c = '0;
      dir_c  = 1'b1;
      brk_c  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      delta_q <= in_word.delta;
      drive_q <= drive_c;
      duty_q  <= duty_c;
      dir_q   <= dir_c;
      brk_q   <= brk_c;
    end
  end

  assign out_data = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                     brk_q, dir_q, duty_q, drive_q, delta_q};

`ifndef SYNTH
  a_brake_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && brk_q) |-> (duty_q == '0 && dir_q && drive_q == '0))
    else $error("brake result carries drive");
  a_run_duty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !brk_q) |-> (duty_q != '0 && (dir_q == drive_q[DRV_W-1])))
    else $error("running result has bad duty or direction");
`endif

endmodule

// ----- tb/encoder_speed_pid_drive_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_speed_pid_drive_test
// Self-checking bench for the encoder speed PID drive. A queue of encoder
// samples feeds a stream driver with random gaps, and a random-stall monitor
// takes each result word. A cycle-free predictor of the speed loop (wrapped
// delta, clamped error sum, PID sum, drive clamp, duty/direction decode)
// checks every field. Registers are rewritten over APB between phases, with
// the block idle: defaults, extremes, inverted limits and random settings.
// ----------------------------------------------------------------------------
module encoder_speed_pid_drive_test;
  import espd_pkg::*;

  typedef struct packed {
    logic signed [15:0] delta;
    logic signed [31:0] drive;
    logic        [30:0] duty;
    logic               dir;
    logic               brake;
  } tick_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_W-1:0]      paddr = '0;
  logic [DATA_W-1:0]      pwdata = '0;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  // Stimulus and expected results
  logic [15:0]  count_samples[$];
  tick_result_t expected_ticks[$];
  int unsigned  send_idle_pct = 35;
  int unsigned  recv_idle_pct = 64;
  int unsigned  mismatch_count = 0;
  logic [15:0]  enc_pos = '0;

  // Shadow registers and loop state of the predictor
  cfg_t         ctl_cfg = '{enable: 1'b0, speed_target: '0, gain_p: GAIN_P_RST,
                            gain_i: '0, gain_d: '0, sum_limit: SUM_LIMIT_RST,
                            drive_min: DRIVE_MIN_RST, drive_max: DRIVE_MAX_RST};
  logic [15:0]  model_last_count = '0;
  longint       model_err_sum = 0;
  longint       model_last_err = 0;

  encoder_speed_pid_drive dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [15:0] encoder_count
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [15:0] delta, [47:16] drive, [78:48] duty,
                           // [79] dir, [80] brake, [87:81] zero
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // One control tick of the speed loop
  function automatic tick_result_t predict_tick(logic [15:0] count);
    tick_result_t r;
    logic [15:0]  raw;
    longint       err, diff, acc, lim, drv, mag;
    raw = count - model_last_count;
    r.delta = raw;
    r.drive = '0;
    r.duty = '0;
    r.dir = 1'b1;
    r.brake = 1'b1;
    model_last_count = count;
    if (ctl_cfg.enable) begin
      err = longint'($signed(ctl_cfg.speed_target)) - longint'($signed(r.delta)) * 256;
      diff = err - model_last_err;
      lim = longint'(ctl_cfg.sum_limit);
      model_err_sum = model_err_sum + err;
      if (model_err_sum > lim) model_err_sum = lim;
      if (model_err_sum < -lim) model_err_sum = -lim;
      model_last_err = err;
      acc = longint'($signed(ctl_cfg.gain_p)) * err
          + longint'($signed(ctl_cfg.gain_i)) * model_err_sum
          + longint'($signed(ctl_cfg.gain_d)) * diff;
      // upper bound first, so inverted limits give drive_min
      drv = acc;
      if (drv > longint'($signed(ctl_cfg.drive_max))) drv = longint'($signed(ctl_cfg.drive_max));
      if (drv < longint'($signed(ctl_cfg.drive_min))) drv = longint'($signed(ctl_cfg.drive_min));
      r.drive = drv[31:0];
      if (drv > 0) begin
        r.duty = drv[30:0];
        r.dir = 1'b0;
        r.brake = 1'b0;
      end else if (drv < 0) begin
        mag = -drv;
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        r.duty = mag[30:0];
        r.brake = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] sext_bits(logic [31:0] v, int w);
    logic [31:0] t;
    t = v << (32 - w);
    return $signed(t) >>> (32 - w);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Sender: next word from the sample queue, random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_ticks.push_back(predict_tick(s_tdata));
      if (!s_tvalid || s_tready) begin
        if (count_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= count_samples.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, compare each word with the oldest expectation
  always @(posedge clk) begin
    tick_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_tvalid && m_tready) begin
        if (expected_ticks.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time, m_tdata);
          mismatch_count++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("measured_delta", {16'h0, want.delta}, {16'h0, m_tdata[15:0]});
          check_field("drive_value", want.drive, m_tdata[47:16]);
          check_field("duty_magnitude", 32'(want.duty), 32'(m_tdata[78:48]));
          check_field("dir_level", 32'(want.dir), 32'(m_tdata[79]));
          check_field("braking", 32'(want.brake), 32'(m_tdata[80]));
          check_field("tdata padding", 32'h0, 32'(m_tdata[87:81]));
        end
      end
    end
  end

  // APB write: setup then access; shadow follows since the block is idle
  task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ENABLE:    ctl_cfg.enable = val[0];
      REG_TARGET:    ctl_cfg.speed_target = val[TGT_W-1:0];
      REG_GAIN_P:    ctl_cfg.gain_p = val[GAIN_W-1:0];
      REG_GAIN_I:    ctl_cfg.gain_i = val[GAIN_W-1:0];
      REG_GAIN_D:    ctl_cfg.gain_d = val[GAIN_W-1:0];
      REG_SUM_LIMIT: ctl_cfg.sum_limit = val[LIM_W-1:0];
      REG_DRIVE_MIN: ctl_cfg.drive_min = val;
      REG_DRIVE_MAX: ctl_cfg.drive_max = val;
      default: ;
    endcase
  endtask

  // Hold off until every queued sample has its result, plus pipeline slack
  task automatic wait_drained();
    while (count_samples.size() != 0 || s_tvalid || expected_ticks.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_config();
    logic [31:0] v;
    cfg_write(REG_ENABLE, {31'd0, ($urandom_range(99) < 85)});
    case ($urandom_range(7))
      0:       v = 32'hFF80_0000;
      1:       v = 32'h007F_FFFF;
      2:       v = sext_bits($urandom, TGT_W);
      default: v = 32'(int'($urandom_range(16384)) - 8192);
    endcase
    cfg_write(REG_TARGET, v);
    for (int g = 0; g < 3; g++) begin
      case ($urandom_range(7))
        0:       v = 32'hFFFF_8000;
        1:       v = 32'h0000_7FFF;
        2:       v = sext_bits($urandom, GAIN_W);
        default: v = 32'(int'($urandom_range(1024)) - 512);
      endcase
      cfg_write(g == 0 ? REG_GAIN_P : (g == 1 ? REG_GAIN_I : REG_GAIN_D), v);
    end
    case ($urandom_range(5))
      0:       v = 32'h0;
      1:       v = 32'h7FFF_FFFF;
      2:       v = $urandom_range(32'h7FFF_FFFF);
      default: v = $urandom_range(1 << 20);
    endcase
    cfg_write(REG_SUM_LIMIT, v);
    case ($urandom_range(7))
      0:       v = 32'h8000_0000;
      1:       v = $urandom;
      2:       v = $urandom_range(1000);
      default: v = 32'(-int'($urandom_range(1 << 24)));
    endcase
    cfg_write(REG_DRIVE_MIN, v);
    case ($urandom_range(7))
      0:       v = 32'h7FFF_FFFF;
      1:       v = $urandom;
      2:       v = 32'(-int'($urandom_range(1000)));
      default: v = $urandom_range(1 << 24);
    endcase
    cfg_write(REG_DRIVE_MAX, v);
  endtask

  // Mostly a motor running near its target speed, with some raw noise
  task automatic queue_run(int n);
    int tgt_counts;
    int step;
    tgt_counts = $signed(ctl_cfg.speed_target) >>> 8;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 15) begin
        enc_pos = 16'($urandom);
      end else begin
        step = tgt_counts + int'($urandom_range(8)) - 4;
        enc_pos = enc_pos + step[15:0];
      end
      count_samples.push_back(enc_pos);
    end
  endtask

  // Directed cases, then random phases
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // disabled at reset: brake, state held, delta extremes
    count_samples = '{16'h0000, 16'h8000, 16'hFFFF, 16'h0000, 16'h1234};
    wait_drained();

    // default gains: zero drive, reverse at drive_min, clamped forward
    cfg_write(REG_ENABLE, 32'd1);
    count_samples = '{16'h1234, 16'h1235, 16'h1233};
    wait_drained();

    // inverted drive limits
    cfg_write(REG_DRIVE_MIN, 32'd100);
    cfg_write(REG_DRIVE_MAX, 32'hFFFF_FF9C);
    count_samples = '{16'h1233, 16'h1240};
    wait_drained();

    // full-scale gains and limits; drive reaches -2^31, duty saturates
    cfg_write(REG_TARGET, 32'hFF80_0000);
    cfg_write(REG_GAIN_P, 32'h0000_7FFF);
    cfg_write(REG_GAIN_I, 32'hFFFF_8000);
    cfg_write(REG_GAIN_D, 32'h0000_7FFF);
    cfg_write(REG_SUM_LIMIT, 32'h7FFF_FFFF);
    cfg_write(REG_DRIVE_MIN, 32'h8000_0000);
    cfg_write(REG_DRIVE_MAX, 32'h7FFF_FFFF);
    count_samples = '{16'h923F, 16'h123F, 16'h123F, 16'hFFFF};
    wait_drained();
    enc_pos = 16'hFFFF;

    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 35;
        recv_idle_pct = 64;
      end else if (ph < 6) begin
        send_idle_pct = 64;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_config();
      queue_run(50);
      wait_drained();
    end

    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && expected_ticks.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
